[src/cfp_pkg.sv]
// cfp_pkg: types, codes and constants shared by the command frame parser
// no dependencies; imported by every module of the block
package cfp_pkg;

  // frame layout
  localparam int unsigned PayloadBytes = 12;
  localparam int unsigned CountW       = 4;
  localparam int unsigned WordW        = 32;

  localparam logic [7:0] SyncFirst  = 8'h55;
  localparam logic [7:0] SyncSecond = 8'hAA;

  // frame type codes
  localparam logic [7:0] TypeRead      = 8'h03;
  localparam logic [7:0] TypeSetLoFrst = 8'h07;
  localparam logic [7:0] TypeSetLoLast = 8'h0E;
  localparam logic [7:0] TypeSetHiFrst = 8'h12;
  localparam logic [7:0] TypeSetHiLast = 8'h15;
  localparam logic [7:0] TypeCal       = 8'h30;

  // controller index of the first type in the upper set-gains range
  localparam logic [3:0] SetHiBase = 4'd8;

  // parser phase
  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_SYNC2   = 3'd1,
    PH_TYPE    = 3'd2,
    PH_PAYLOAD = 3'd3,
    PH_TRAILER = 3'd4
  } phase_e;

  // decoded command
  typedef enum logic [1:0] {
    CMD_OTHER     = 2'd0,
    CMD_READ_GAIN = 2'd1,
    CMD_SET_GAIN  = 2'd2,
    CMD_GYRO_CAL  = 2'd3
  } cmd_e;

  // completed frame handed from the tracker to the result register
  typedef struct packed {
    logic             emit;
    logic [7:0]       frame_type;
    logic [7:0]       trailer;
    logic [WordW-1:0] word_first;
    logic [WordW-1:0] word_second;
    logic [WordW-1:0] word_third;
  } frame_t;

  // decoded command fields
  typedef struct packed {
    cmd_e       command;
    logic [3:0] controller_index;
    logic       reply_requested;
  } cmd_t;

endpackage

[src/cfp_decode.sv]
// cfp_decode: maps a frame type byte to command, controller index and reply flag
// depends on cfp_pkg
module cfp_decode import cfp_pkg::*; (
  input  logic [7:0] frame_type_i,
  output cmd_t       cmd_o
);

  // type classification
  always_comb begin
    cmd_o = '{command: CMD_OTHER, controller_index: 4'd0, reply_requested: 1'b0};
    if (frame_type_i == TypeRead) begin
      cmd_o.command         = CMD_READ_GAIN;
      cmd_o.reply_requested = 1'b1;
    end else if (frame_type_i inside {[TypeSetLoFrst:TypeSetLoLast]}) begin
      cmd_o.command          = CMD_SET_GAIN;
      cmd_o.controller_index = 4'(frame_type_i - TypeSetLoFrst);
      cmd_o.reply_requested  = 1'b1;
    end else if (frame_type_i inside {[TypeSetHiFrst:TypeSetHiLast]}) begin
      cmd_o.command          = CMD_SET_GAIN;
      cmd_o.controller_index = 4'(frame_type_i - TypeSetHiFrst) + SetHiBase;
      cmd_o.reply_requested  = 1'b1;
    end else if (frame_type_i == TypeCal) begin
      cmd_o.command = CMD_GYRO_CAL;
    end
  end

endmodule

[src/cfp_frame_track.sv]
// cfp_frame_track: input register, phase state machine and payload store
// depends on cfp_pkg; feeds the result register in the top level
module cfp_frame_track import cfp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [7:0] rx_byte_i,
  input  logic       advance_i,
  output logic       in_stall_o,
  output frame_t     frame_o
);

  logic              in_vld_q;
  logic [7:0]        in_byte_q;
  logic              step;
  phase_e            phase_q, phase_d;
  logic [CountW-1:0] count_q, count_d;
  logic [CountW-1:0] count_inc;
  logic [7:0]        held_type_q;
  logic [7:0]        store_q [PayloadBytes];
  logic              store_we;
  logic              type_we;
  logic              emit;

  assign in_stall_o = in_vld_q & ~advance_i;
  assign step       = in_vld_q & advance_i;
  assign count_inc  = count_q + CountW'(1);

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_byte_q <= rx_byte_i;
    end
  end

  // next phase and payload index
  always_comb begin
    phase_d = phase_q;
    count_d = count_q;
    if (step) begin
      case (phase_q)
        PH_SYNC2: begin
          phase_d = (in_byte_q == SyncSecond) ? PH_TYPE : PH_HUNT;
        end
        PH_TYPE: begin
          count_d = '0;
          phase_d = PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          if (count_q < CountW'(PayloadBytes) &&
              count_inc < CountW'(PayloadBytes)) begin
            count_d = count_inc;
          end else begin
            count_d = '0;
            phase_d = PH_TRAILER;
          end
        end
        PH_TRAILER: begin
          count_d = '0;
          phase_d = PH_HUNT;
        end
        default: begin
          phase_d = (in_byte_q == SyncFirst) ? PH_SYNC2 : PH_HUNT;
        end
      endcase
    end
  end

  // store writes and frame completion
  always_comb begin
    type_we  = 1'b0;
    store_we = 1'b0;
    emit     = 1'b0;
    case (phase_q)
      PH_TYPE:    type_we  = step;
      PH_PAYLOAD: store_we = step & (count_q < CountW'(PayloadBytes));
      PH_TRAILER: emit     = step;
      default:    ;
    endcase
  end

  assign frame_o.emit        = emit;
  assign frame_o.frame_type  = held_type_q;
  assign frame_o.trailer     = in_byte_q;
  assign frame_o.word_first  = {store_q[3], store_q[2], store_q[1], store_q[0]};
  assign frame_o.word_second = {store_q[7], store_q[6], store_q[5], store_q[4]};
  assign frame_o.word_third  = {store_q[11], store_q[10], store_q[9], store_q[8]};

  // phase and index registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      count_q <= '0;
    end else begin
      phase_q <= phase_d;
      count_q <= count_d;
    end
  end

  // type byte and payload bytes
  always_ff @(posedge clk_i) begin
    if (type_we) begin
      held_type_q <= in_byte_q;
    end
    for (int i = 0; i < PayloadBytes; i++) begin
      if (store_we && count_q == CountW'(i)) begin
        store_q[i] <= in_byte_q;
      end
    end
  end

endmodule

[src/command_frame_parser_top.sv]
// Command frame parser: takes one received byte per transfer and finds 16-byte
// frames (0x55, 0xAA, type, 12 payload bytes, trailer). A byte can be
// transferred in every cycle while the input side does not stall; a result is
// offered once its trailer byte has passed through the input register and the
// result register has loaded. The input side stalls only while a result waits
// and the output side stalls. Bytes outside a frame give no result.
//
// top level: instantiates cfp_frame_track and cfp_decode, holds the result register
// depends on cfp_pkg
module command_frame_parser_top import cfp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  frame_type_o,
  output logic [1:0]  command_o,
  output logic [3:0]  controller_index_o,
  output logic [31:0] word_first_o,
  output logic [31:0] word_second_o,
  output logic [31:0] word_third_o,
  output logic [7:0]  trailer_byte_o,
  output logic        reply_requested_o
);

  logic   advance;
  frame_t frame;
  cmd_t   cmd;
  logic   out_vld_q;
  frame_t res_q;
  cmd_t   res_cmd_q;

  // the result register can take a new frame when empty or being drained
  assign advance = ~out_vld_q | ~out_stall_i;

  cfp_frame_track u_track (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .rx_byte_i  (rx_byte_i),
    .advance_i  (advance),
    .in_stall_o (in_stall_o),
    .frame_o    (frame)
  );

  cfp_decode u_decode (
    .frame_type_i (frame.frame_type),
    .cmd_o        (cmd)
  );

  // result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (frame.emit) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (frame.emit) begin
      res_q     <= frame;
      res_cmd_q <= cmd;
    end
  end

  assign out_valid_o        = out_vld_q;
  assign frame_type_o       = res_q.frame_type;
  assign command_o          = res_cmd_q.command;
  assign controller_index_o = res_cmd_q.controller_index;
  assign word_first_o       = res_q.word_first;
  assign word_second_o      = res_q.word_second;
  assign word_third_o       = res_q.word_third;
  assign trailer_byte_o     = res_q.trailer;
  assign reply_requested_o  = res_cmd_q.reply_requested;

  // emit is part of the stored frame but only the valid flag carries it out
  logic unused_emit;
  assign unused_emit = res_q.emit;

endmodule

[src/cfp_checker.sv]
// cfp_checker: port-level assertions for the command frame parser
// depends on cfp_pkg; bound to command_frame_parser_top at the end of this file
module cfp_checker import cfp_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic [7:0]  rx_byte_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [7:0]  frame_type_o,
  input logic [1:0]  command_o,
  input logic [3:0]  controller_index_o,
  input logic [31:0] word_first_o,
  input logic [31:0] word_second_o,
  input logic [31:0] word_third_o,
  input logic [7:0]  trailer_byte_o,
  input logic        reply_requested_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(frame_type_o) &&
      $stable(command_o) && $stable(word_first_o) && $stable(trailer_byte_o))
    else $error("stalled result changed");

  // reply flag follows the command
  a_reply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> reply_requested_o ==
      (command_o == CMD_READ_GAIN || command_o == CMD_SET_GAIN))
    else $error("reply flag does not match command");

  // controller index only for set gains, and in range
  a_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (command_o == CMD_SET_GAIN) ? (controller_index_o <= 4'd11)
                                                : (controller_index_o == 4'd0))
    else $error("controller index out of place");

  // command agrees with the type byte
  a_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((command_o == CMD_READ_GAIN) == (frame_type_o == TypeRead)) &&
      ((command_o == CMD_GYRO_CAL) == (frame_type_o == TypeCal)))
    else $error("command does not match type");

  // input stalls only while a result is held back
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output backpressure");

  logic unused_ok;
  assign unused_ok = ^{in_valid_i, rx_byte_i, word_second_o, word_third_o};

endmodule

bind command_frame_parser_top cfp_checker u_cfp_checker (.*);

[tb/tb_command_frame_parser_top.sv]
// tb_command_frame_parser_top: self-checking testbench for the command frame parser
// drives framed and broken byte streams through the valid/stall ports, predicts every
// result with an in-bench frame tracker; depends on cfp_pkg and command_frame_parser_top
module tb_command_frame_parser_top import cfp_pkg::*; ();

  localparam int unsigned RandomBytes = 1240;
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned LongHold    = 300;
  localparam int unsigned NumRows     = 13;

  // one completed frame as seen on the result ports
  typedef struct packed {
    logic [7:0]  frame_type;
    cmd_e        command;
    logic [3:0]  controller_index;
    logic [31:0] word_first;
    logic [31:0] word_second;
    logic [31:0] word_third;
    logic [7:0]  trailer_byte;
    logic        reply_requested;
  } frame_result_t;

  // directed frame: optional lead bytes, then sync, type, payload and trailer
  typedef struct packed {
    logic [1:0] lead_n;
    logic [7:0] lead0;
    logic [7:0] lead1;
    logic [7:0] ftype;
    logic [7:0] fill;
    logic       ramp;
    logic [7:0] trailer;
    logic       typed;
    cmd_e       cmd;
    logic [3:0] idx;
    logic       reply;
  } frame_row_t;

  // typed rows carry flat payloads so the words read straight off the fill byte
  localparam frame_row_t DirRows [NumRows] = '{
    '{2'd0, 8'h00, 8'h00, 8'h03, 8'h00, 1'b0, 8'h00, 1'b1, CMD_READ_GAIN, 4'd0,  1'b1},
    '{2'd0, 8'h00, 8'h00, 8'h07, 8'hFF, 1'b0, 8'hFF, 1'b1, CMD_SET_GAIN,  4'd0,  1'b1},
    '{2'd0, 8'h00, 8'h00, 8'h0E, 8'hA5, 1'b0, 8'h5A, 1'b1, CMD_SET_GAIN,  4'd7,  1'b1},
    '{2'd0, 8'h00, 8'h00, 8'h12, 8'h00, 1'b0, 8'h81, 1'b1, CMD_SET_GAIN,  4'd8,  1'b1},
    '{2'd0, 8'h00, 8'h00, 8'h15, 8'hFF, 1'b0, 8'h7E, 1'b1, CMD_SET_GAIN,  4'd11, 1'b1},
    '{2'd0, 8'h00, 8'h00, 8'h30, 8'h3C, 1'b0, 8'hC3, 1'b1, CMD_GYRO_CAL,  4'd0,  1'b0},
    '{2'd0, 8'h00, 8'h00, 8'h00, 8'hFF, 1'b0, 8'h00, 1'b1, CMD_OTHER,     4'd0,  1'b0},
    '{2'd0, 8'h00, 8'h00, 8'hFF, 8'h00, 1'b0, 8'hFF, 1'b1, CMD_OTHER,     4'd0,  1'b0},
    '{2'd0, 8'h00, 8'h00, 8'h0F, 8'h11, 1'b0, 8'h22, 1'b1, CMD_OTHER,     4'd0,  1'b0},
    '{2'd0, 8'h00, 8'h00, 8'h11, 8'h10, 1'b1, 8'h33, 1'b0, CMD_OTHER,     4'd0,  1'b0},
    // wrong second sync byte ahead of a good frame
    '{2'd2, 8'h55, 8'h13, 8'h08, 8'hF0, 1'b1, 8'h44, 1'b0, CMD_OTHER,     4'd0,  1'b0},
    // repeated first sync: the second 0x55 is not taken as a new start
    '{2'd2, 8'h55, 8'h55, 8'h14, 8'h96, 1'b0, 8'h69, 1'b1, CMD_SET_GAIN,  4'd10, 1'b1},
    // lone 0x55 swallows the frame's own sync, so the frame is lost
    '{2'd1, 8'h55, 8'h00, 8'h30, 8'h00, 1'b0, 8'h00, 1'b0, CMD_OTHER,     4'd0,  1'b0}
  };

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  rx_byte_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [7:0]  frame_type_o;
  logic [1:0]  command_o;
  logic [3:0]  controller_index_o;
  logic [31:0] word_first_o;
  logic [31:0] word_second_o;
  logic [31:0] word_third_o;
  logic [7:0]  trailer_byte_o;
  logic        reply_requested_o;

  command_frame_parser_top dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .rx_byte_i          (rx_byte_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .frame_type_o       (frame_type_o),
    .command_o          (command_o),
    .controller_index_o (controller_index_o),
    .word_first_o       (word_first_o),
    .word_second_o      (word_second_o),
    .word_third_o       (word_third_o),
    .trailer_byte_o     (trailer_byte_o),
    .reply_requested_o  (reply_requested_o)
  );

  // frame tracker state, mirrors the parser
  phase_e        trk_phase;
  logic [3:0]    trk_count;
  logic [7:0]    trk_type;
  logic [7:0]    trk_payload [PayloadBytes];
  frame_result_t pending_frames [$];

  int unsigned mismatches;
  int unsigned results_seen;
  int unsigned bytes_sent;
  int unsigned cycle_count;
  logic        sender_quiet;
  logic        receiver_quiet;

  // clock
  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // cycle limit
  initial cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // advance the tracker by one transferred byte, queue a result after a trailer
  task automatic track_byte(input logic [7:0] b);
    frame_result_t r;
    case (trk_phase)
      PH_SYNC2: trk_phase = (b == SyncSecond) ? PH_TYPE : PH_HUNT;
      PH_TYPE: begin
        trk_type  = b;
        trk_count = '0;
        trk_phase = PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        if (trk_count < PayloadBytes) begin
          trk_payload[trk_count] = b;
          trk_count = trk_count + 4'd1;
          if (trk_count >= PayloadBytes) begin
            trk_count = '0;
            trk_phase = PH_TRAILER;
          end
        end else begin
          // stray index: drop the byte and go for the trailer
          trk_count = '0;
          trk_phase = PH_TRAILER;
        end
      end
      PH_TRAILER: begin
        r.frame_type       = trk_type;
        r.command          = CMD_OTHER;
        r.controller_index = '0;
        r.reply_requested  = 1'b0;
        if (trk_type == TypeRead) begin
          r.command         = CMD_READ_GAIN;
          r.reply_requested = 1'b1;
        end else if (trk_type >= TypeSetLoFrst && trk_type <= TypeSetLoLast) begin
          r.command          = CMD_SET_GAIN;
          r.controller_index = 4'(trk_type - TypeSetLoFrst);
          r.reply_requested  = 1'b1;
        end else if (trk_type >= TypeSetHiFrst && trk_type <= TypeSetHiLast) begin
          r.command          = CMD_SET_GAIN;
          r.controller_index = SetHiBase + 4'(trk_type - TypeSetHiFrst);
          r.reply_requested  = 1'b1;
        end else if (trk_type == TypeCal) begin
          r.command = CMD_GYRO_CAL;
        end
        r.word_first   = {trk_payload[3], trk_payload[2], trk_payload[1], trk_payload[0]};
        r.word_second  = {trk_payload[7], trk_payload[6], trk_payload[5], trk_payload[4]};
        r.word_third   = {trk_payload[11], trk_payload[10], trk_payload[9], trk_payload[8]};
        r.trailer_byte = b;
        pending_frames.push_back(r);
        trk_phase = PH_HUNT;
        trk_count = '0;
      end
      // hunt, and any unused phase code
      default: trk_phase = (b == SyncFirst) ? PH_SYNC2 : PH_HUNT;
    endcase
  endtask

  // offer one byte after a random gap and hold it until the transfer
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    if ($urandom_range(0, 99) < 3) sender_quiet = ~sender_quiet;
    gap = sender_quiet ? 0 : $urandom_range(0, 16);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (in_stall_o);
    bytes_sent++;
    track_byte(b);
  endtask

  // full frame: sync pair, type, payload bytes low first, trailer
  task automatic send_frame(input logic [7:0] ftype, input logic [95:0] payload,
                            input logic [7:0] trailer);
    send_byte(SyncFirst);
    send_byte(SyncSecond);
    send_byte(ftype);
    for (int k = 0; k < PayloadBytes; k++) send_byte(payload[8*k +: 8]);
    send_byte(trailer);
  endtask

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  // result checker
  always @(posedge clk_i) begin
    frame_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (pending_frames.size() == 0) begin
        $error("result with nothing expected, frame_type %0h", frame_type_o);
        mismatches++;
      end else begin
        want = pending_frames.pop_front();
        check_field("frame_type", want.frame_type, frame_type_o);
        check_field("command", want.command, command_o);
        check_field("controller_index", want.controller_index, controller_index_o);
        check_field("word_first", want.word_first, word_first_o);
        check_field("word_second", want.word_second, word_second_o);
        check_field("word_third", want.word_third, word_third_o);
        check_field("trailer_byte", want.trailer_byte, trailer_byte_o);
        check_field("reply_requested", want.reply_requested, reply_requested_o);
      end
    end
  end

  // result side: random stall before each transfer, two long holds to back up the input
  initial begin
    int unsigned hold_cycles;
    int unsigned holds_done;
    holds_done = 0;
    wait (rst_ni);
    forever begin
      if ($urandom_range(0, 99) < 3) receiver_quiet = ~receiver_quiet;
      if ((holds_done == 0 && results_seen >= 10) || (holds_done == 1 && results_seen >= 50)) begin
        hold_cycles = LongHold;
        holds_done++;
      end else begin
        hold_cycles = receiver_quiet ? 0 : $urandom_range(0, 16);
      end
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold_cycles) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
      do @(posedge clk_i); while (!(out_valid_o && !out_stall_i));
    end
  end

  // stimulus
  initial begin
    frame_row_t    row;
    frame_result_t typed;
    logic [95:0]   payload;
    logic [7:0]    ftype;
    logic [7:0]    b;
    int unsigned   stop_at;

    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    rx_byte_i      = '0;
    out_stall_i    = 1'b0;
    sender_quiet   = 1'b0;
    receiver_quiet = 1'b0;
    mismatches     = 0;
    results_seen   = 0;
    bytes_sent     = 0;
    trk_phase      = PH_HUNT;
    trk_count      = '0;
    trk_type       = '0;
    for (int k = 0; k < PayloadBytes; k++) trk_payload[k] = '0;

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed frames
    for (int i = 0; i < NumRows; i++) begin
      row = DirRows[i];
      if (row.lead_n > 0) send_byte(row.lead0);
      if (row.lead_n > 1) send_byte(row.lead1);
      for (int k = 0; k < PayloadBytes; k++) begin
        payload[8*k +: 8] = row.ramp ? row.fill + 8'(k) : row.fill;
      end
      send_frame(row.ftype, payload, row.trailer);
      if (row.typed && pending_frames.size() > 0) begin
        typed.frame_type       = row.ftype;
        typed.command          = row.cmd;
        typed.controller_index = row.idx;
        typed.word_first       = {4{row.fill}};
        typed.word_second      = {4{row.fill}};
        typed.word_third       = {4{row.fill}};
        typed.trailer_byte     = row.trailer;
        typed.reply_requested  = row.reply;
        pending_frames[pending_frames.size() - 1] = typed;
      end
    end

    // random part: mostly good frames, some line noise and broken sync pairs
    stop_at = bytes_sent + RandomBytes;
    while (bytes_sent < stop_at) begin
      case ($urandom_range(0, 9))
        0: repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
        1: begin
          send_byte(SyncFirst);
          do b = 8'($urandom_range(0, 255)); while (b == SyncSecond);
          send_byte(b);
        end
        default: begin
          case ($urandom_range(0, 4))
            0:       ftype = 8'($urandom_range(0, 255));
            1:       ftype = TypeRead;
            2:       ftype = 8'($urandom_range(TypeSetLoFrst, TypeSetLoLast));
            3:       ftype = 8'($urandom_range(TypeSetHiFrst, TypeSetHiLast));
            default: ftype = TypeCal;
          endcase
          payload = {$urandom(), $urandom(), $urandom()};
          send_frame(ftype, payload, 8'($urandom_range(0, 255)));
        end
      endcase
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;

    // drain, then leave room for anything unexpected to show up
    while (pending_frames.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatches == 0 && pending_frames.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
